@@ hw/rtl/lrt_pkg.sv @@
// Package for the LRU tile residency list: sizes, opcodes, state codes,
// cell control type and the limit clamp. No dependencies.
package lrt_pkg;

	localparam int CAPACITY  = 8;
	localparam int ID_BITS   = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OPCODE_W  = 2;
	localparam int TILE_ID_W = 16;
	localparam int CFG_W     = 4;

	localparam logic [OPCODE_W-1:0] OP_TOUCH  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FIND  = 4'b0010,
		S_EVICT = 4'b0100,
		S_RESP  = 4'b1000
	} lrt_state_t;

	typedef struct packed {
		logic shift;  // take the right neighbor's id
		logic load;   // take the new id (wins over shift)
	} lrt_cell_ctl_t;

	// Clamp the configured limit to 1..CAPACITY.
	function automatic logic [CNT_W-1:0] eff_limit(input logic [CFG_W-1:0] m);
		logic [CNT_W-1:0] r;
		if (m == '0) begin
			r = CNT_W'(1);
		end else if (int'(m) > CAPACITY) begin
			r = CNT_W'(CAPACITY);
		end else begin
			r = CNT_W'(m);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/lrt_if.sv @@
// Valid/ready channel interfaces for the request and result transactions.
// Depends on lrt_pkg.
interface lrt_req_if import lrt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [OPCODE_W-1:0]  opcode;
	logic [TILE_ID_W-1:0] tile_id;

	modport source (output valid, output opcode, output tile_id, input ready);
	modport sink (input valid, input opcode, input tile_id, output ready);
endinterface

interface lrt_rsp_if import lrt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 evict_valid;
	logic [TILE_ID_W-1:0] evicted_id;
	logic                 last;

	modport source (output valid, output hit, output evict_valid, output evicted_id,
		output last, input ready);
	modport sink (input valid, input hit, input evict_valid, input evicted_id,
		input last, output ready);
endinterface

@@ hw/rtl/lrt_cell.sv @@
// One list slot: holds an id, compares it to the key, passes the
// "match seen to the left" flag on. Depends on lrt_pkg.
module lrt_cell import lrt_pkg::*; (
	input  logic               clk,
	input  lrt_cell_ctl_t      ctl,
	input  logic [ID_BITS-1:0] right_id,
	input  logic [ID_BITS-1:0] new_id,
	input  logic [ID_BITS-1:0] key,
	input  logic               valid,
	input  logic               seen_in,
	output logic               seen_out,
	output logic [ID_BITS-1:0] id
);

	logic [ID_BITS-1:0] id_q;

	assign id       = id_q;
	assign seen_out = seen_in | (valid && (id_q == key));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q <= new_id;
		end else if (ctl.shift) begin
			id_q <= right_id;
		end
	end

endmodule

@@ hw/rtl/lru_tile_residency_list.sv @@
// LRU tile residency list: a row of CAPACITY slot cells, oldest at cell 0.
// A request is captured in IDLE, searched in FIND and answered from EVICT or RESP.
// A new request is taken only back in IDLE. Evictions shift out of cell 0, one evicted
// id per cycle while the result register is free; output stalls hold EVICT and RESP.
// Reset (arst_n low): list empty, limit 1, no result pending; slot ids undefined.
module lru_tile_residency_list import lrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lrt_req_if.sink          req,
	lrt_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	lrt_state_t          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CFG_W-1:0]    max_cached_q;
	logic [OPCODE_W-1:0] op_q;
	logic [ID_BITS-1:0]  key_q;
	logic                hit_q;

	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	logic                 rsp_evict_q;
	logic [TILE_ID_W-1:0] rsp_id_q;
	logic                 rsp_last_q;

	// Cell row wiring
	lrt_cell_ctl_t      ctl [CAPACITY];
	logic [ID_BITS-1:0] cell_id [CAPACITY];
	logic               seen [CAPACITY+1];
	logic [CAPACITY-1:0] cell_valid;

	logic             rsp_free;
	logic             rsp_load;    // a result transaction is registered this cycle
	logic [CNT_W-1:0] limit;
	logic             evict_now;   // list is full for the pending append
	logic             evict_last;  // this eviction makes room exactly
	logic             found;
	logic             drop;

	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load   = rsp_free && ((state_q == S_EVICT) || (state_q == S_RESP));
	assign limit      = eff_limit(max_cached_q);
	assign evict_now  = (count_q >= limit);
	assign evict_last = (count_q == limit);
	assign found      = seen[CAPACITY];
	assign drop       = (op_q == OP_TOUCH) || (op_q == OP_REMOVE);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.evict_valid = rsp_evict_q;
	assign rsp.evicted_id  = rsp_id_q;
	assign rsp.last        = rsp_last_q;

	assign seen[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [ID_BITS-1:0] right;
			if (gi == CAPACITY - 1) begin : g_end
				assign right = cell_id[gi];
			end else begin : g_mid
				assign right = cell_id[gi+1];
			end
			assign cell_valid[gi] = (CNT_W'(gi) < count_q);

			lrt_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[gi]),
				.right_id (right),
				.new_id   (key_q),
				.key      (key_q),
				.valid    (cell_valid[gi]),
				.seen_in  (seen[gi]),
				.seen_out (seen[gi+1]),
				.id       (cell_id[gi])
			);
		end
	endgenerate

	// Per-cell control. FIND (touch or remove): cells at and right of the match close the gap.
	// EVICT: either shift everything left (evict cell 0, and on the final
	// eviction drop the key into the freed tail), or append at the tail.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i] = '0;
			case (state_q)
				S_FIND: begin
					ctl[i].shift = drop && seen[i+1];
				end
				S_EVICT: begin
					if (rsp_free) begin
						if (evict_now) begin
							ctl[i].shift = 1'b1;
							ctl[i].load  = evict_last && (CNT_W'(i) == count_q - CNT_W'(1));
						end else begin
							ctl[i].load = (CNT_W'(i) == count_q);
						end
					end
				end
				default: begin
					ctl[i] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			max_cached_q <= CFG_W'(1);
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_cached_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (drop && found) begin
						count_q <= count_q - CNT_W'(1);
					end else if (op_q == OP_CLEAR) begin
						count_q <= '0;
					end
					state_q <= (op_q == OP_TOUCH) ? S_EVICT : S_RESP;
				end
				S_EVICT: begin
					if (rsp_free) begin
						if (evict_now) begin
							if (evict_last) begin
								state_q <= S_IDLE;
							end else begin
								count_q <= count_q - CNT_W'(1);
							end
						end else begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, hit flag and result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.opcode;
			key_q <= ID_BITS'(req.tile_id);
		end
		if (state_q == S_FIND) begin
			hit_q <= drop && found;
		end
		if (state_q == S_EVICT && rsp_free) begin
			rsp_hit_q   <= hit_q;
			rsp_evict_q <= evict_now;
			rsp_id_q    <= evict_now ? TILE_ID_W'(cell_id[0]) : '0;
			rsp_last_q  <= !evict_now || evict_last;
		end
		if (state_q == S_RESP && rsp_free) begin
			rsp_hit_q   <= hit_q;
			rsp_evict_q <= 1'b0;
			rsp_id_q    <= '0;
			rsp_last_q  <= 1'b1;
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for lru_tile_residency_list: directed and random request transactions,
// each result transaction checked against an in-bench LRU list. Needs lrt_pkg, lrt_if, RTL.
module testbench;
	import lrt_pkg::*;

	// One result transaction as the block should present it.
	typedef struct packed {
		logic                 hit;
		logic                 evict_valid;
		logic [TILE_ID_W-1:0] evicted_id;
		logic                 last;
	} lru_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lrt_req_if req_ch ();
	lrt_rsp_if rsp_ch ();

	lru_tile_residency_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// ---------------------------------------------------------------
	// Shadow state: resident ids oldest first, the limit register and
	// the results still owed by the block, oldest first.
	// ---------------------------------------------------------------
	logic [ID_BITS-1:0]   resident_ids[$];
	logic [CFG_W-1:0]     limit_cfg = CFG_W'(1);
	lru_result_t          results_due[$];
	int                   mismatches = 0;

	// Traffic shaping knobs, set by the test tasks.
	bit                   tx_idle_en = 1'b1;
	bit                   rx_idle_en = 1'b1;
	int                   hold_request = 0;   // receiver hold-off length, in cycles
	logic [TILE_ID_W-1:0] id_pool[12];        // small working set so touches hit

	function automatic void owe_result(input logic hit, input logic evict,
		input logic [TILE_ID_W-1:0] evicted, input logic last);
		lru_result_t r;
		r.hit         = hit;
		r.evict_valid = evict;
		r.evicted_id  = evicted;
		r.last        = last;
		results_due = {results_due, r};
	endfunction

	// Applies one accepted request to the shadow list and queues what it owes.
	function automatic void track_residency(input logic [OPCODE_W-1:0] op,
		input logic [TILE_ID_W-1:0] tile);
		logic [ID_BITS-1:0] key;
		int                 pos;
		int                 lim;
		int                 surplus;
		logic               present;
		key = tile[ID_BITS-1:0];
		pos = -1;
		foreach (resident_ids[i]) begin
			if (pos < 0 && resident_ids[i] == key) begin
				pos = i;
			end
		end
		present = (pos >= 0);
		case (op)
			OP_TOUCH: begin
				// move to newest, then trim from the oldest end down to the limit
				if (present) begin
					resident_ids.delete(pos);
				end
				resident_ids = {resident_ids, key};
				if (limit_cfg == '0) begin
					lim = 1;
				end else if (int'(limit_cfg) > CAPACITY) begin
					lim = CAPACITY;
				end else begin
					lim = int'(limit_cfg);
				end
				surplus = resident_ids.size() - lim;
				if (surplus <= 0) begin
					owe_result(present, 1'b0, '0, 1'b1);
				end else begin
					for (int k = 0; k < surplus; k++) begin
						owe_result(present, 1'b1, TILE_ID_W'(resident_ids[0]),
							k == surplus - 1);
						resident_ids.delete(0);
					end
				end
			end
			OP_REMOVE: begin
				// no trim here even if the list sits above a lowered limit
				if (present) begin
					resident_ids.delete(pos);
				end
				owe_result(present, 1'b0, '0, 1'b1);
			end
			OP_CLEAR: begin
				resident_ids.delete();
				owe_result(1'b0, 1'b0, '0, 1'b1);
			end
			default: begin
				// no-op opcode: list untouched, bare completion
				owe_result(1'b0, 1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [TILE_ID_W-1:0] want,
		input logic [TILE_ID_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Clock, watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The slowest legal run ends far before this watchdog fires.
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Request monitor: every accepted request transaction feeds the model.
	// Results are registered only after FIND and then EVICT or RESP, so predicting and
	// checking in the same time step never race.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			track_residency(req_ch.opcode, req_ch.tile_id);
		end
	end

	// Result checker: each accepted result transaction against the oldest owed one.
	always @(posedge clk) begin : rsp_check
		lru_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual hit=%b ev=%b id=%h last=%b",
					$time, rsp_ch.hit, rsp_ch.evict_valid, rsp_ch.evicted_id, rsp_ch.last);
				mismatches++;
			end else begin
				want = results_due[0];
				results_due.delete(0);
				check_field("hit", want.hit, rsp_ch.hit);
				check_field("evict_valid", want.evict_valid, rsp_ch.evict_valid);
				check_field("evicted_id", want.evicted_id, rsp_ch.evicted_id);
				check_field("last", want.last, rsp_ch.last);
			end
		end
	end

	// ---------------------------------------------------------------
	// Result receiver: random ready drops, plus a long hold-off on request.
	// The hold-off is counted down here, one cycle per edge.
	// ---------------------------------------------------------------
	initial begin : rsp_sink
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_request > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left = hold_request - 1;
				hold_request = 0;
			end else if (rx_idle_en && $urandom_range(99) < 23) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender side. Every task starts and ends on a rising edge.
	// valid stays high from one transaction to the next unless a gap is drawn.
	// ---------------------------------------------------------------
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [TILE_ID_W-1:0] tile);
		if (tx_idle_en && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.tile_id <= tile;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed result. At least one edge first so the
	// monitor has seen a transaction accepted on the current edge.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (results_due.size() != 0);
		repeat (4) @(posedge clk);   // let the FSM settle back to idle
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_cfg = value;
	endtask

	// Working set: both id extremes, a few small ids, a few full-width ones.
	task automatic refresh_pool();
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < 12; i++) begin
			id_pool[i] = (i < 8) ? TILE_ID_W'($urandom_range(1, 20)) : TILE_ID_W'($urandom);
		end
	endtask

	function automatic logic [TILE_ID_W-1:0] pick_tile();
		if ($urandom_range(99) < 80) begin
			return id_pool[$urandom_range(11)];
		end
		return TILE_ID_W'($urandom);
	endfunction

	// Mostly touches, with removes mixed in; clears and no-ops stay rare so the
	// list gets deep enough to evict.
	function automatic logic [OPCODE_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return OP_TOUCH;
		end else if (r < 90) begin
			return OP_REMOVE;
		end else if (r < 95) begin
			return OP_CLEAR;
		end
		return OP_NOP;
	endfunction

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_item(pick_op(), pick_tile());
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Limit is 1 out of reset: append, hit, evict on a new id, remove a hit.
	task automatic test_reset_limit();
		send_item(OP_TOUCH, 16'h0005);
		send_item(OP_TOUCH, 16'h0005);
		send_item(OP_TOUCH, 16'h0007);
		send_item(OP_REMOVE, 16'h0007);
	endtask

	// Limit 0 acts as 1, 15 saturates to CAPACITY, lowering the limit trims on the
	// next touch only (full list down to one gives the most evictions at once).
	task automatic test_limit_extremes();
		write_limit(CFG_W'(0));
		send_item(OP_TOUCH, 16'hFFFF);
		send_item(OP_TOUCH, 16'h0000);
		write_limit(CFG_W'(15));
		for (int i = 1; i <= CAPACITY + 1; i++) begin
			send_item(OP_TOUCH, TILE_ID_W'(i));
		end
		write_limit(CFG_W'(1));
		send_item(OP_TOUCH, 16'hA5A5);
		write_limit(CFG_W'(CAPACITY));
		send_item(OP_TOUCH, 16'h000A);
		send_item(OP_TOUCH, 16'h000B);
		send_item(OP_TOUCH, 16'h000C);
		// list above limit: removes must not evict, the touch after trims two
		write_limit(CFG_W'(2));
		send_item(OP_REMOVE, 16'h000B);
		send_item(OP_REMOVE, 16'h0063);
		send_item(OP_TOUCH, 16'h0000);
	endtask

	task automatic test_clear_and_nop();
		send_item(OP_TOUCH, 16'h0003);
		send_item(OP_CLEAR, 16'h1234);
		send_item(OP_NOP, 16'hFFFF);
		send_item(OP_CLEAR, 16'h0000);
	endtask

	// Random traffic over several limit settings, extremes among them.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] limits[7];
		limits = '{CFG_W'(3), CFG_W'(CAPACITY), CFG_W'(1), CFG_W'(12), CFG_W'(5), CFG_W'(0),
			CFG_W'($urandom)};
		foreach (limits[p]) begin
			write_limit(limits[p]);
			refresh_pool();
			send_random(55);
		end
	endtask

	// Receiver holds off long enough for the block to fill and stall requests;
	// then the sender stops until every owed result is back.
	task automatic test_backpressure();
		write_limit(CFG_W'(4));
		refresh_pool();
		hold_request = 100;
		send_random(30);
		wait_drained();
	endtask

	// A stretch with neither side idling.
	task automatic test_full_rate();
		write_limit(CFG_W'(6));
		refresh_pool();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random(40);
		wait_drained();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_NOP;
		req_ch.tile_id <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limit();
		test_limit_extremes();
		test_clear_and_nop();
		test_random_traffic();
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (10) @(posedge clk);   // catch any stray result after the last one
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lrt_pkg.sv
hw/rtl/lrt_if.sv
hw/rtl/lrt_cell.sv
hw/rtl/lru_tile_residency_list.sv
sim/testbench.sv
